// ===== rtl/core/gtl_pkg.sv =====
package gtl_pkg;

  localparam int GLYPH_SIZE_DEF  = 32;
  localparam int GLYPH_BYTES_DEF = 128;
  localparam int LINE_GAP_DEF    = 10;

  localparam logic [15:0] WRAP_WIDTH_RST = 16'd320;

  localparam logic [7:0] BYTE_END    = 8'h00;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_WIDE   = 8'h80;
  localparam logic [7:0] BYTE_GB_LO  = 8'hA1;
  localparam logic [7:0] BYTE_GB_BAD = 8'hFF;

  // glyphs per GB2312 row
  localparam int GB_ROW = 94;

  typedef enum logic [1:0] {
    KIND_HALF  = 2'd0,
    KIND_GB    = 2'd1,
    KIND_BLANK = 2'd2
  } glyph_kind_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic        string_start;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } text_item_t;

  typedef struct packed {
    glyph_kind_t glyph_kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [6:0]  char_code;
    logic [20:0] glyph_offset;
  } glyph_t;

  typedef struct packed {
    logic       valid;
    text_item_t item;
  } stage_t;

endpackage

// ===== rtl/core/gtl_if.sv =====
interface gtl_text_if;
  import gtl_pkg::*;
  logic       valid;
  logic       ready;
  text_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtl_glyph_if;
  import gtl_pkg::*;
  logic   valid;
  logic   ready;
  glyph_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gtl_in_reg.sv =====
module gtl_in_reg (
  input  logic           clk,
  input  logic           rst,
  gtl_text_if.sink       text,
  input  logic           take,
  output gtl_pkg::stage_t stage
);
  import gtl_pkg::*;

  logic       valid;
  text_item_t item;

  // refill whenever the held word moves on this cycle
  assign text.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (text.ready) begin
      valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item <= text.data;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// ===== rtl/core/gtl_engine.sv =====
module gtl_engine #(
  parameter int GLYPH_SIZE  = gtl_pkg::GLYPH_SIZE_DEF,
  parameter int GLYPH_BYTES = gtl_pkg::GLYPH_BYTES_DEF,
  parameter int LINE_GAP    = gtl_pkg::LINE_GAP_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  gtl_pkg::stage_t stage,
  input  logic [15:0]     wrap_width,
  output logic            take,
  gtl_glyph_if.source     glyph
);
  import gtl_pkg::*;

  localparam logic [17:0] ADV_FULL  = 18'(GLYPH_SIZE);
  localparam logic [17:0] ADV_HALF  = 18'(GLYPH_SIZE / 2);
  localparam logic [15:0] LINE_STEP = 16'(GLYPH_SIZE + LINE_GAP);
  localparam int IDX_W  = $clog2(GB_ROW * GB_ROW);
  localparam int GB_W   = $clog2(GLYPH_BYTES + 1);
  localparam int PROD_W = IDX_W + GB_W;

  logic [15:0] pen_x, pen_x_next;
  logic [15:0] pen_y, pen_y_next;
  logic [15:0] line_start_x, line_start_x_next;
  logic [7:0]  pending_high, pending_high_next;
  logic        pending_valid, pending_valid_next;

  logic [15:0] cur_x, cur_y, cur_ls;
  logic [7:0]  cur_ph;
  logic        cur_pv;
  logic [7:0]  code;
  logic        is_half;
  logic [17:0] adv;
  logic        need_wrap;
  logic [15:0] wrap_x, wrap_y;
  logic [7:0]  hi_rel, lo_rel;
  logic [IDX_W-1:0]  idx;
  logic [PROD_W-1:0] prod;
  logic        gb_bad;
  logic        emit;
  glyph_t      res;

  assign take = stage.valid && (!glyph.valid || glyph.ready);

  always_comb begin
    code = stage.item.code_byte;
    if (stage.item.string_start) begin
      cur_x  = stage.item.start_x;
      cur_y  = stage.item.start_y;
      cur_ls = stage.item.start_x;
      cur_ph = BYTE_END;
      cur_pv = 1'b0;
    end else begin
      cur_x  = pen_x;
      cur_y  = pen_y;
      cur_ls = line_start_x;
      cur_ph = pending_high;
      cur_pv = pending_valid;
    end

    // unsigned wrap test on zero-extended values, rearranged: pen + advance > line start + width
    is_half   = code < BYTE_WIDE;
    adv       = is_half ? ADV_HALF : ADV_FULL;
    need_wrap = ({2'b00, cur_x} + adv) > ({2'b00, cur_ls} + {2'b00, wrap_width});
    wrap_x    = need_wrap ? cur_ls : cur_x;
    wrap_y    = need_wrap ? cur_y + LINE_STEP : cur_y;

    // row times 94 as 64 + 32 - 2
    hi_rel = cur_ph - BYTE_GB_LO;
    lo_rel = code - BYTE_GB_LO;
    idx    = (IDX_W'(hi_rel[6:0]) << 6) + (IDX_W'(hi_rel[6:0]) << 5)
           - (IDX_W'(hi_rel[6:0]) << 1) + IDX_W'(lo_rel[6:0]);
    prod   = PROD_W'(idx) * PROD_W'(GLYPH_BYTES);
    gb_bad = (code == BYTE_END) || (cur_ph < BYTE_GB_LO) || (cur_ph == BYTE_GB_BAD)
          || (code < BYTE_GB_LO) || (code == BYTE_GB_BAD);

    pen_x_next         = cur_x;
    pen_y_next         = cur_y;
    line_start_x_next  = cur_ls;
    pending_high_next  = cur_ph;
    pending_valid_next = cur_pv;
    emit               = 1'b0;
    res.glyph_kind     = KIND_BLANK;
    res.pos_x          = cur_x;
    res.pos_y          = cur_y;
    res.char_code      = 7'd0;
    res.glyph_offset   = 21'd0;

    if (cur_pv) begin
      emit               = 1'b1;
      pending_valid_next = 1'b0;
      pending_high_next  = BYTE_END;
      pen_x_next         = cur_x + 16'(GLYPH_SIZE);
      if (!gb_bad) begin
        res.glyph_kind   = KIND_GB;
        res.glyph_offset = 21'(prod);
      end
    end else if (code == BYTE_END || code == BYTE_CR) begin
      // drop: nothing to draw
    end else if (code == BYTE_LF) begin
      pen_x_next = cur_ls;
      pen_y_next = cur_y + LINE_STEP;
    end else if (is_half) begin
      emit           = 1'b1;
      res.glyph_kind = KIND_HALF;
      res.pos_x      = wrap_x;
      res.pos_y      = wrap_y;
      res.char_code  = code[6:0];
      pen_x_next     = wrap_x + 16'(ADV_HALF);
      pen_y_next     = wrap_y;
    end else begin
      // hold the lead byte until its partner arrives
      pen_x_next         = wrap_x;
      pen_y_next         = wrap_y;
      pending_high_next  = code;
      pending_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x         <= 16'd0;
      pen_y         <= 16'd0;
      line_start_x  <= 16'd0;
      pending_high  <= BYTE_END;
      pending_valid <= 1'b0;
    end else if (take) begin
      pen_x         <= pen_x_next;
      pen_y         <= pen_y_next;
      line_start_x  <= line_start_x_next;
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph.valid <= 1'b0;
    end else if (take) begin
      glyph.valid <= emit;
    end else if (glyph.ready) begin
      glyph.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      glyph.data <= res;
    end
  end

endmodule

// ===== rtl/core/gb2312_text_layout.sv =====
// Text layout for a GB2312 font: takes one string byte per word on text and
// gives glyph draw commands (kind, pen position, ASCII code or bitmap offset)
// on glyph. One byte is accepted every clock cycle, stalls aside; each byte
// is held in the input register and its command in the result register, and
// the pen update between them is what paces the stream. Line feed, carriage
// return, a lead byte and the string terminator without a pending lead byte
// give no command. wrap_width is written on cfg, always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
module gb2312_text_layout #(
  parameter int GLYPH_SIZE  = gtl_pkg::GLYPH_SIZE_DEF,
  parameter int GLYPH_BYTES = gtl_pkg::GLYPH_BYTES_DEF,
  parameter int LINE_GAP    = gtl_pkg::LINE_GAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  gtl_text_if.sink    text,
  gtl_glyph_if.source glyph,
  gtl_cfg_if.sink     cfg
);
  import gtl_pkg::*;

  logic [15:0] wrap_width;
  stage_t      stage;
  logic        take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= WRAP_WIDTH_RST;
    end else if (cfg.valid) begin
      wrap_width <= cfg.data;
    end
  end

  gtl_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .take  (take),
    .stage (stage)
  );

  gtl_engine #(
    .GLYPH_SIZE  (GLYPH_SIZE),
    .GLYPH_BYTES (GLYPH_BYTES),
    .LINE_GAP    (LINE_GAP)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .wrap_width (wrap_width),
    .take       (take),
    .glyph      (glyph)
  );

endmodule

// ===== rtl/core/gtl_checker.sv =====
module gtl_checker (
  input logic            clk,
  input logic            rst,
  input logic            glyph_valid,
  input logic            glyph_ready,
  input gtl_pkg::glyph_t glyph_data
);
  import gtl_pkg::*;

  // an unaccepted word stays put
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && !glyph_ready |=> glyph_valid)
    else $error("glyph word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && !glyph_ready |=> $stable(glyph_data))
    else $error("glyph word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !glyph_valid)
    else $error("glyph word present after reset");

  a_code_only_half: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && glyph_data.glyph_kind != KIND_HALF |-> glyph_data.char_code == 7'd0)
    else $error("char code set on a full-width glyph");

  a_offset_only_gb: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && glyph_data.glyph_kind != KIND_GB |-> glyph_data.glyph_offset == 21'd0)
    else $error("bitmap offset set on a non-GB2312 glyph");

endmodule

bind gb2312_text_layout gtl_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .glyph_valid (glyph.valid),
  .glyph_ready (glyph.ready),
  .glyph_data  (glyph.data)
);

// ===== sim/gb2312_text_layout_tb.sv =====
`timescale 1ns / 1ps

module gb2312_text_layout_tb;
  import gtl_pkg::*;

  localparam int ADV_FULL = GLYPH_SIZE_DEF;
  localparam int ADV_HALF = GLYPH_SIZE_DEF / 2;
  localparam int LINE_H   = GLYPH_SIZE_DEF + LINE_GAP_DEF;
  localparam int PHASES   = 7;
  localparam int PHASE_N  = 135;

  logic clk;
  logic rst;

  gtl_text_if  text_if ();
  gtl_glyph_if glyph_if ();
  gtl_cfg_if   cfg_if ();

  gb2312_text_layout u_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .glyph (glyph_if),
    .cfg   (cfg_if)
  );

  // layout state as the block should hold it
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] line_x;
  logic [7:0]  lead_byte;
  bit          lead_held;
  logic [15:0] wrap_w;

  text_item_t  byte_q[$];
  glyph_t      glyph_q[$];
  int          issued_cnt;
  int          fed_cnt;
  int          checked_cnt;
  int          err_cnt;
  int          src_gap;
  int          snk_gap;
  bit          idle_en;
  bit          hit;
  glyph_t      pred;
  glyph_t      want;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic next_line();
    pen_x = line_x;
    pen_y = pen_y + 16'(LINE_H);
  endtask

  task automatic wrap_check(input int adv);
    int lim;
    lim = int'(line_x) + int'(wrap_w) - adv;
    if (int'(pen_x) > lim) next_line();
  endtask

  // advance the layout by one byte; hit is set when a draw command results
  task automatic layout_byte(input text_item_t it, output bit got, output glyph_t g);
    logic [7:0] b;
    int         idx;
    b = it.code_byte;
    got = 1'b0;
    g = '0;
    if (it.string_start) begin
      pen_x = it.start_x;
      pen_y = it.start_y;
      line_x = it.start_x;
      lead_held = 1'b0;
      lead_byte = '0;
    end
    if (lead_held) begin
      g.glyph_kind = KIND_BLANK;
      g.pos_x = pen_x;
      g.pos_y = pen_y;
      if (!(b == BYTE_END || lead_byte < BYTE_GB_LO || lead_byte == BYTE_GB_BAD ||
            b < BYTE_GB_LO || b == BYTE_GB_BAD)) begin
        idx = GB_ROW * (int'(lead_byte) - int'(BYTE_GB_LO)) + (int'(b) - int'(BYTE_GB_LO));
        g.glyph_kind = KIND_GB;
        g.glyph_offset = 21'(idx * GLYPH_BYTES_DEF);
      end
      lead_held = 1'b0;
      lead_byte = '0;
      pen_x = pen_x + 16'(ADV_FULL);
      got = 1'b1;
    end else if (b == BYTE_LF) begin
      next_line();
    end else if (b != BYTE_END && b != BYTE_CR) begin
      if (b < BYTE_WIDE) begin
        wrap_check(ADV_HALF);
        g.glyph_kind = KIND_HALF;
        g.pos_x = pen_x;
        g.pos_y = pen_y;
        g.char_code = b[6:0];
        pen_x = pen_x + 16'(ADV_HALF);
        got = 1'b1;
      end else begin
        wrap_check(ADV_FULL);
        lead_byte = b;
        lead_held = 1'b1;
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input bit ss = 1'b0,
                          input logic [15:0] sx = 16'h0, input logic [15:0] sy = 16'h0);
    text_item_t it;
    it.code_byte = b;
    it.string_start = ss;
    it.start_x = sx;
    it.start_y = sy;
    byte_q.push_back(it);
    issued_cnt++;
  endtask

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2) return 16'($urandom_range(0, 400));
    if (r == 2) return 16'($urandom_range(65000, 65535));
    return 16'($urandom);
  endfunction

  // mostly well-formed text with random content, some broken pairs and noise
  task automatic random_text(input int n);
    int          cnt;
    int          r;
    bit          ss;
    logic [15:0] sx;
    logic [15:0] sy;
    cnt = 0;
    while (cnt < n) begin
      ss = (cnt == 0) || ($urandom_range(0, 11) == 0);
      sx = ss ? pick_coord() : 16'($urandom);
      sy = ss ? pick_coord() : 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        add_byte(8'($urandom_range(8'h20, 8'h7E)), ss, sx, sy);
        cnt += 1;
      end else if (r < 55) begin
        add_byte(8'($urandom_range(1, 8'h7F)), ss, sx, sy);
        cnt += 1;
      end else if (r < 75) begin
        add_byte(8'($urandom_range(BYTE_GB_LO, 8'hFE)), ss, sx, sy);
        add_byte(8'($urandom_range(BYTE_GB_LO, 8'hFE)), 1'b0, 16'($urandom), 16'($urandom));
        cnt += 2;
      end else if (r < 82) begin
        add_byte(8'($urandom_range(BYTE_WIDE, 8'hFF)), ss, sx, sy);
        add_byte(8'($urandom_range(0, 255)));
        cnt += 2;
      end else if (r < 87) begin
        add_byte(BYTE_END, ss, sx, sy);
        cnt += 1;
      end else if (r < 90) begin
        add_byte(8'($urandom_range(BYTE_WIDE, 8'hFF)), ss, sx, sy);
        add_byte(BYTE_END);
        cnt += 2;
      end else if (r < 95) begin
        add_byte(BYTE_LF, ss, sx, sy);
        cnt += 1;
      end else begin
        add_byte(8'($urandom), ss, sx, sy);
        cnt += 1;
      end
    end
  endtask

  // hold until every byte is taken and every command is back, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (fed_cnt != issued_cnt || glyph_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [15:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk);
    while (!cfg_if.ready);
    wrap_w = v;
    cfg_if.valid <= 1'b0;
  endtask

  // text driver
  always @(posedge clk) begin
    if (rst) begin
      text_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        layout_byte(text_if.data, hit, pred);
        if (hit) glyph_q.push_back(pred);
        fed_cnt++;
      end
      if (!text_if.valid || text_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          text_if.valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          text_if.valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
          src_gap = $urandom_range(0, 2);
          text_if.valid <= 1'b0;
        end else begin
          text_if.valid <= 1'b1;
          text_if.data <= byte_q.pop_front();
        end
      end
    end
  end

  // glyph monitor
  always @(posedge clk) begin
    if (rst) begin
      glyph_if.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (glyph_if.valid && glyph_if.ready) begin
        if (glyph_q.size() == 0) begin
          report_mismatch($sformatf("unexpected glyph %p", glyph_if.data));
        end else begin
          want = glyph_q.pop_front();
          checked_cnt++;
          if (glyph_if.data.glyph_kind !== want.glyph_kind)
            report_mismatch($sformatf("glyph_kind %0d, want %0d",
                                      glyph_if.data.glyph_kind, want.glyph_kind));
          if (glyph_if.data.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x %0d, want %0d", glyph_if.data.pos_x, want.pos_x));
          if (glyph_if.data.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y %0d, want %0d", glyph_if.data.pos_y, want.pos_y));
          if (glyph_if.data.char_code !== want.char_code)
            report_mismatch($sformatf("char_code %0h, want %0h",
                                      glyph_if.data.char_code, want.char_code));
          if (glyph_if.data.glyph_offset !== want.glyph_offset)
            report_mismatch($sformatf("glyph_offset %0d, want %0d",
                                      glyph_if.data.glyph_offset, want.glyph_offset));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        glyph_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 2);
        glyph_if.ready <= 1'b0;
      end else begin
        glyph_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [15:0] widths [PHASES];
    int          p;
    clk = 1'b0;
    rst = 1'b1;
    text_if.valid = 1'b0;
    text_if.data = '0;
    glyph_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    pen_x = '0;
    pen_y = '0;
    line_x = '0;
    lead_byte = '0;
    lead_held = 1'b0;
    wrap_w = WRAP_WIDTH_RST;
    issued_cnt = 0;
    fed_cnt = 0;
    checked_cnt = 0;
    err_cnt = 0;
    idle_en = 1'b1;
    widths = '{WRAP_WIDTH_RST, 16'd0, 16'hFFFF, 16'd16, 16'd48,
               16'($urandom_range(17, 1000)), WRAP_WIDTH_RST};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, pair handling, CR/LF, terminator, restart
    add_byte(8'h41, 1'b1, 16'h0000, 16'h0000);
    add_byte(8'h7F);
    add_byte(8'h01);
    add_byte(BYTE_CR);
    add_byte(BYTE_LF);
    add_byte(8'hB0);
    add_byte(BYTE_GB_LO);
    add_byte(BYTE_GB_LO);
    add_byte(BYTE_GB_LO);
    add_byte(8'hFE);
    add_byte(8'hFE);
    add_byte(BYTE_WIDE);
    add_byte(8'h41);
    add_byte(BYTE_GB_BAD);
    add_byte(8'hB0);
    add_byte(8'hB0);
    add_byte(BYTE_GB_BAD);
    add_byte(8'hC0);
    add_byte(BYTE_CR);
    add_byte(8'hC0);
    add_byte(BYTE_LF);
    add_byte(8'hC0);
    add_byte(BYTE_END);
    add_byte(BYTE_END);
    add_byte(8'h5A, 1'b1, 16'hFFFF, 16'hFFFF);
    add_byte(8'hB0);
    add_byte(8'h61, 1'b1, 16'd300, 16'd20);
    add_byte(8'hD6);
    add_byte(8'hD0);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        cfg_write(widths[p]);
      end
      // quiet final stretch: no gaps on either side
      if (p == PHASES - 1) idle_en = 1'b0;
      else idle_en = (p != 3);
      random_text(PHASE_N);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (glyph_q.size() != 0)
      report_mismatch($sformatf("%0d glyph commands never arrived", glyph_q.size()));
    $display("%0d text bytes fed, %0d glyph commands checked over %0d wrap widths",
             fed_cnt, checked_cnt, PHASES);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gtl_pkg.sv
rtl/core/gtl_if.sv
rtl/core/gtl_in_reg.sv
rtl/core/gtl_engine.sv
rtl/core/gb2312_text_layout.sv
rtl/core/gtl_checker.sv
sim/gb2312_text_layout_tb.sv
